// ===== design/slbm_pkg.sv =====
// ----------------------------------------------------------------------------
// slbm_pkg
// Shared types and constants for the serial-loaded bank mapper.
// ----------------------------------------------------------------------------
package slbm_pkg;

	localparam int WORK_RAM_BYTES_DEF = 8192;
	localparam int RAM_IDX_W          = 13;   // CPU window 0x6000-0x7FFF

	// request kinds
	localparam logic [1:0] REQ_CPU_RD = 2'd0;
	localparam logic [1:0] REQ_CPU_WR = 2'd1;
	localparam logic [1:0] REQ_PPU_RD = 2'd2;
	localparam logic [1:0] REQ_PPU_WR = 2'd3;

	// outcome codes
	localparam logic [1:0] OC_NONE  = 2'd0;
	localparam logic [1:0] OC_ADDR  = 2'd1;
	localparam logic [1:0] OC_RAM   = 2'd2;
	localparam logic [1:0] OC_CLAIM = 2'd3;

	// load register targets (bus_addr[14:13])
	localparam logic [1:0] TGT_CTRL    = 2'd0;
	localparam logic [1:0] TGT_CHR_LO  = 2'd1;
	localparam logic [1:0] TGT_CHR_HI  = 2'd2;
	localparam logic [1:0] TGT_PRG     = 2'd3;

	// config register indexes
	localparam logic REG_PRG_COUNT = 1'b0;
	localparam logic REG_CHR_COUNT = 1'b1;

	localparam logic [4:0] CTRL_RESET     = 5'h1C;
	localparam logic [4:0] PRG_COUNT_RST  = 5'd16;
	localparam logic [4:0] CHR_COUNT_RST  = 5'd0;

	typedef struct packed {
		logic [1:0]           outcome;
		logic [17:0]          rom_addr;
		logic [1:0]           mirror;
		logic                 ram_rd;
		logic                 ram_wr;
		logic [RAM_IDX_W-1:0] ram_idx;
	} xlate_t;

endpackage

// ===== design/slbm_xlate.sv =====
// ----------------------------------------------------------------------------
// slbm_xlate
// Mapper register file, serial loader and address translation.
// ----------------------------------------------------------------------------
module slbm_xlate (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic [1:0]          req_type,
	input  logic [15:0]         bus_addr,
	input  logic [7:0]          write_data,
	input  logic [4:0]          prg_bank_count,
	input  logic [4:0]          chr_bank_count,
	output slbm_pkg::xlate_t    res
);
	import slbm_pkg::*;

	logic [4:0] shift_value_q;
	logic [2:0] shift_count_q;
	logic [4:0] control_q;
	logic [4:0] chr_low_q;
	logic [4:0] chr_high_q;
	logic [4:0] chr_full_q;
	logic [2:0] prg_full_q;
	logic [3:0] prg_low_q;
	logic [3:0] prg_high_q;
	logic [1:0] mirror_q;

	logic       is_cpu;
	logic       in_ram_win;
	logic       reg_wr;
	logic [4:0] shift_nx;
	logic [2:0] count_nx;
	logic       commit;
	logic [3:0] prg_bank;
	logic [4:0] chr_bank;
	logic [3:0] prg_last;

	assign is_cpu     = (req_type == REQ_CPU_RD) || (req_type == REQ_CPU_WR);
	assign in_ram_win = (bus_addr[15:13] == 3'b011);
	assign reg_wr     = accept && (req_type == REQ_CPU_WR) && bus_addr[15];
	assign shift_nx   = {write_data[0], shift_value_q[4:1]};
	assign count_nx   = shift_count_q + 3'd1;
	assign commit     = (count_nx >= 3'd5);
	assign prg_last   = 4'(prg_bank_count - 5'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_value_q <= '0;
			shift_count_q <= '0;
			control_q     <= CTRL_RESET;
			chr_low_q     <= '0;
			chr_high_q    <= '0;
			chr_full_q    <= '0;
			prg_full_q    <= '0;
			prg_low_q     <= '0;
			prg_high_q    <= 4'(PRG_COUNT_RST - 5'd1);
			mirror_q      <= '0;
		end else if (reg_wr) begin
			if (write_data[7]) begin
				shift_value_q <= '0;
				shift_count_q <= '0;
				control_q     <= control_q | 5'h0C;
			end else if (!commit) begin
				shift_value_q <= shift_nx;
				shift_count_q <= count_nx;
			end else begin
				shift_value_q <= '0;
				shift_count_q <= '0;
				case (bus_addr[14:13])
					TGT_CTRL: begin
						control_q <= shift_nx;
						mirror_q  <= shift_nx[1:0];
					end
					TGT_CHR_LO: begin
						if (control_q[4]) chr_low_q <= shift_nx;
						else chr_full_q <= shift_nx & 5'h1E;
					end
					TGT_CHR_HI: begin
						if (control_q[4]) chr_high_q <= shift_nx;
					end
					default: begin
						if (!control_q[3]) begin
							prg_full_q <= shift_nx[3:1];
						end else if (!control_q[2]) begin
							prg_low_q  <= '0;
							prg_high_q <= shift_nx[3:0];
						end else begin
							prg_low_q  <= shift_nx[3:0];
							prg_high_q <= prg_last;
						end
					end
				endcase
			end
		end
	end

	assign prg_bank = bus_addr[14] ? prg_high_q : prg_low_q;
	assign chr_bank = bus_addr[12] ? chr_high_q : chr_low_q;

	always_comb begin
		res          = '0;
		res.ram_idx  = bus_addr[RAM_IDX_W-1:0];
		// mirroring as it stands after this transfer
		res.mirror   = mirror_q;
		if (reg_wr && !write_data[7] && commit && (bus_addr[14:13] == TGT_CTRL))
			res.mirror = shift_nx[1:0];
		if (is_cpu) begin
			if (in_ram_win) begin
				res.outcome = OC_RAM;
				res.ram_wr  = (req_type == REQ_CPU_WR);
				res.ram_rd  = (req_type == REQ_CPU_RD);
			end else if (bus_addr[15] && (req_type == REQ_CPU_RD)) begin
				res.outcome = OC_ADDR;
				if (control_q[3]) res.rom_addr = {prg_bank, bus_addr[13:0]};
				else res.rom_addr = {prg_full_q, bus_addr[14:0]};
			end
		end else if (bus_addr[15:13] == 3'b000) begin
			if (chr_bank_count == 5'd0) begin
				res.outcome  = OC_ADDR;
				res.rom_addr = {2'b00, bus_addr};
			end else if (req_type == REQ_PPU_WR) begin
				res.outcome = OC_CLAIM;
			end else begin
				res.outcome = OC_ADDR;
				if (control_q[4]) res.rom_addr = {1'b0, chr_bank, bus_addr[11:0]};
				else res.rom_addr = {1'b0, chr_full_q[4:1], bus_addr[12:0]};
			end
		end
	end

endmodule

// ===== design/serial_loaded_bank_mapper_top.sv =====
// ----------------------------------------------------------------------------
// serial_loaded_bank_mapper_top
// Serial-loaded bank mapper: translates CPU/PPU bus accesses and holds the
// cartridge work RAM.
// ----------------------------------------------------------------------------
// Stages: the work RAM read stage, then the output register.
// Throughput: one transfer per cycle unless both stages are full and the
//   consumer stalls; the work RAM has one port and each item uses it at
//   most once, at the cycle it is accepted.
// Reset: arst_n clears the pipeline and the mapper registers to power-on
//   values at once; work RAM contents are undefined until written, so no
//   clearing pass is run.
module serial_loaded_bank_mapper_top #(
	parameter int WORK_RAM_BYTES = slbm_pkg::WORK_RAM_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic [15:0] bus_addr,
	input  logic [7:0]  write_data,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  outcome,
	output logic [17:0] rom_addr,
	output logic [7:0]  read_data,
	output logic [1:0]  mirror_mode,
	// APB configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import slbm_pkg::*;

	localparam int RAM_AW = $clog2(WORK_RAM_BYTES);

	// ---------------------------------------------------------------- config
	logic [4:0] prg_count_q;
	logic [4:0] chr_count_q;
	logic       cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prg_count_q <= PRG_COUNT_RST;
			chr_count_q <= CHR_COUNT_RST;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_PRG_COUNT: prg_count_q <= pwdata[4:0];
				REG_CHR_COUNT: chr_count_q <= pwdata[4:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_PRG_COUNT: prdata = {27'd0, prg_count_q};
			REG_CHR_COUNT: prdata = {27'd0, chr_count_q};
			default:       prdata = '0;
		endcase
	end

	// ------------------------------------------------------------ handshake
	// Stage 1 holds an item while its work RAM read is in flight; stage 2 is
	// the output register. Stage 1 drains whenever stage 2 is empty or its
	// transfer completes, so a new item enters every cycle unless both stages
	// are full and the consumer stalls.
	logic   accept;
	logic   s2_free;
	logic   adv;
	xlate_t xl;

	logic   valid_s1;
	xlate_t res_s1;
	logic   valid_s2;
	logic   rd_s2;

	assign s2_free  = !valid_s2 || !out_stall;
	assign adv      = valid_s1 && s2_free;
	assign in_stall = valid_s1 && !s2_free;
	assign accept   = in_valid && !in_stall;

	// mapper registers update on the accepting edge; next item sees them
	slbm_xlate u_xlate (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.req_type       (req_type),
		.bus_addr       (bus_addr),
		.write_data     (write_data),
		.prg_bank_count (prg_count_q),
		.chr_bank_count (chr_count_q),
		.res            (xl)
	);

	// -------------------------------------------------------------- work RAM
	// Single port, one access per accepted item. Reads and writes to one entry
	// are always at distinct edges, so no forwarding is needed. The read
	// register only changes on accept, which cannot happen while stage 1 is
	// stuck, so it stays valid until stage 1 moves on.
	logic [7:0]        work_ram [WORK_RAM_BYTES];
	logic [7:0]        ram_rd_q;
	logic [RAM_AW-1:0] ram_addr;

	assign ram_addr = RAM_AW'(xl.ram_idx);

	always_ff @(posedge clk) begin
		if (accept && xl.ram_wr) work_ram[ram_addr] <= write_data;
		if (accept && xl.ram_rd) ram_rd_q <= work_ram[ram_addr];
	end

	// -------------------------------------------------------------- pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (accept) valid_s1 <= 1'b1;
			else if (adv) valid_s1 <= 1'b0;
			if (adv) valid_s2 <= 1'b1;
			else if (!out_stall) valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) res_s1 <= xl;
		if (adv) begin
			outcome     <= res_s1.outcome;
			rom_addr    <= res_s1.rom_addr;
			mirror_mode <= res_s1.mirror;
			rd_s2       <= res_s1.ram_rd;
			read_data   <= res_s1.ram_rd ? ram_rd_q : 8'd0;
		end
	end

	assign out_valid = valid_s2;

	// ------------------------------------------------------------ assertions
	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && out_stall))
		else $error("input stalled with a free pipeline slot");

	a_rd_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !rd_s2) |-> (read_data == 8'd0))
		else $error("read_data nonzero on a result without a work RAM read");

	a_rd_is_ram: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && rd_s2) |-> (outcome == OC_RAM))
		else $error("work RAM read delivered with wrong outcome");

	a_addr_only_mapped: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (outcome != OC_ADDR)) |-> (rom_addr == 18'd0))
		else $error("rom_addr nonzero on an unmapped result");

endmodule

// ===== sim/tb_serial_loaded_bank_mapper_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_serial_loaded_bank_mapper_top
// Self-checking bench for the serial-loaded bank mapper. Every accepted bus
// access is run through a local predictor of the mapper (load register, bank
// registers, work RAM, mirroring); each result transfer is compared against
// the oldest prediction. Directed window and serial-load checks come first,
// then random traffic across several bank-count settings with random idling
// on both channels, and a final back-to-back stretch with no idling.
// ----------------------------------------------------------------------------
module tb_serial_loaded_bank_mapper_top;
	import slbm_pkg::*;

	localparam int         RAM_BYTES       = 8192;
	localparam int         DRAIN_CYCLES    = 4;          // pipeline is 2 deep, plus margin
	localparam int         PHASE_ITEMS     = 200;
	localparam int         FINAL_ITEMS     = 120;
	localparam int         TIMEOUT_NS      = 10_000_000;
	localparam logic [4:0] CTRL_CHR_4K     = 5'h10;      // CHR in two 4 KB banks
	localparam logic [4:0] CTRL_PRG_16K    = 5'h08;      // PRG in 16 KB banks
	localparam logic [4:0] CTRL_PRG_FIX    = 5'h0C;      // forced by a load reset
	localparam logic [1:0] PRG_MODE_FIX_LO = 2'd2;
	localparam logic [1:0] PRG_MODE_FIX_HI = 2'd3;
	localparam logic [7:0] LOAD_RESET      = 8'h80;

	typedef struct packed {
		logic [1:0]  outcome;
		logic [17:0] rom_addr;
		logic [7:0]  read_data;
		logic [1:0]  mirror;
	} xlation_t;

	// DUT signals; every input starts at a known value
	logic        clk        = 1'b0;
	logic        arst_n     = 1'b0;
	logic        in_valid   = 1'b0;
	logic        in_stall;
	logic [1:0]  req_type   = REQ_CPU_RD;
	logic [15:0] bus_addr   = 16'd0;
	logic [7:0]  write_data = 8'd0;
	logic        out_valid;
	logic        out_stall  = 1'b0;
	logic [1:0]  outcome;
	logic [17:0] rom_addr;
	logic [7:0]  read_data;
	logic [1:0]  mirror_mode;
	logic        psel       = 1'b0;
	logic        penable    = 1'b0;
	logic        pwrite     = 1'b0;
	logic [2:0]  paddr      = 3'd0;
	logic [31:0] pwdata     = 32'd0;
	logic [31:0] prdata;
	logic        pready;

	// Predicted mapper state, power-on values
	logic [4:0]  prg_count    = PRG_COUNT_RST;
	logic [4:0]  chr_count    = CHR_COUNT_RST;
	logic [4:0]  ld_shift     = 5'd0;
	logic [2:0]  ld_count     = 3'd0;
	logic [4:0]  ctrl_q       = CTRL_RESET;
	logic [4:0]  chr_lo_bank  = 5'd0;
	logic [4:0]  chr_hi_bank  = 5'd0;
	logic [4:0]  chr_8k_bank  = 5'd0;
	logic [2:0]  prg_32k_bank = 3'd0;
	logic [3:0]  prg_lo_bank  = 4'd0;
	logic [3:0]  prg_hi_bank  = 4'd15;   // bank count 16, minus one
	logic [1:0]  mirror_q     = 2'd0;
	logic [7:0]  wram [RAM_BYTES];
	bit          wram_written [RAM_BYTES];
	logic [12:0] written_list [$];       // work RAM offsets safe to read back

	xlation_t    expected_xlations [$];
	int unsigned fail_count = 0;
	int unsigned items_sent = 0;
	bit          idling_on  = 1'b0;

	serial_loaded_bank_mapper_top u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.req_type   (req_type),
		.bus_addr   (bus_addr),
		.write_data (write_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.outcome    (outcome),
		.rom_addr   (rom_addr),
		.read_data  (read_data),
		.mirror_mode(mirror_mode),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Fifth serial write: commit the load register to the target picked by
	// address bits 14:13 of that write.
	function automatic void commit_load(input logic [15:0] addr);
		logic [4:0] v;
		logic [4:0] last_bank;
		v = ld_shift;
		last_bank = prg_count - 5'd1;
		case (addr[14:13])
		TGT_CTRL: begin
			ctrl_q   = v;
			mirror_q = v[1:0];
		end
		TGT_CHR_LO: begin
			if ((ctrl_q & CTRL_CHR_4K) != 5'd0) chr_lo_bank = v;
			else chr_8k_bank = v & 5'h1E;
		end
		TGT_CHR_HI: begin
			// ignored in 8 KB CHR mode
			if ((ctrl_q & CTRL_CHR_4K) != 5'd0) chr_hi_bank = v;
		end
		TGT_PRG: begin
			if (ctrl_q[3:2] == PRG_MODE_FIX_LO) begin
				prg_lo_bank = 4'd0;
				prg_hi_bank = v[3:0];
			end else if (ctrl_q[3:2] == PRG_MODE_FIX_HI) begin
				prg_lo_bank = v[3:0];
				prg_hi_bank = last_bank[3:0];   // picks up the current bank count
			end else begin
				prg_32k_bank = v[3:1];
			end
		end
		endcase
		ld_shift = 5'd0;
		ld_count = 3'd0;
	endfunction

	// Predicts the translation of one accepted access and updates the state.
	function automatic xlation_t translate_access(input logic [1:0] kind,
			input logic [15:0] addr, input logic [7:0] data);
		xlation_t   r;
		logic [3:0] pbank;
		logic [4:0] cbank;
		r = '0;
		if (kind == REQ_CPU_RD || kind == REQ_CPU_WR) begin
			if (addr >= 16'h6000 && addr <= 16'h7FFF) begin
				if (kind == REQ_CPU_WR) begin
					wram[addr[12:0]] = data;
					if (!wram_written[addr[12:0]]) begin
						wram_written[addr[12:0]] = 1'b1;
						written_list.push_back(addr[12:0]);
					end
				end else begin
					r.read_data = wram[addr[12:0]];
				end
				r.outcome = OC_RAM;
			end else if (addr[15]) begin
				if (kind == REQ_CPU_WR) begin
					if (data[7]) begin
						ld_shift = 5'd0;
						ld_count = 3'd0;
						ctrl_q   = ctrl_q | CTRL_PRG_FIX;
					end else begin
						ld_shift = {data[0], ld_shift[4:1]};
						ld_count = ld_count + 3'd1;
						if (ld_count >= 3'd5) commit_load(addr);
					end
				end else begin
					if ((ctrl_q & CTRL_PRG_16K) != 5'd0) begin
						pbank = (addr < 16'hC000) ? prg_lo_bank : prg_hi_bank;
						r.rom_addr = {pbank, addr[13:0]};
					end else begin
						r.rom_addr = {prg_32k_bank, addr[14:0]};
					end
					r.outcome = OC_ADDR;
				end
			end
		end else if (addr < 16'h2000) begin
			if (chr_count == 5'd0) begin
				// CHR RAM: pattern address passes through
				r.rom_addr = {5'd0, addr[12:0]};
				r.outcome  = OC_ADDR;
			end else if (kind == REQ_PPU_WR) begin
				r.outcome = OC_CLAIM;
			end else begin
				if ((ctrl_q & CTRL_CHR_4K) != 5'd0) begin
					cbank = (addr < 16'h1000) ? chr_lo_bank : chr_hi_bank;
					r.rom_addr = {1'b0, cbank, addr[11:0]};
				end else begin
					// 8 KB mode drops the bank's low bit
					r.rom_addr = {1'b0, chr_8k_bank[4:1], addr[12:0]};
				end
				r.outcome = OC_ADDR;
			end
		end
		r.mirror = mirror_q;
		return r;
	endfunction

	// One request transfer; an optional idle burst goes ahead of it.
	task automatic send_access(input logic [1:0] kind, input logic [15:0] addr,
			input logic [7:0] data);
		if (idling_on && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		in_valid   <= 1'b1;
		req_type   <= kind;
		bus_addr   <= addr;
		write_data <= data;
		do @(posedge clk); while (in_stall);
		expected_xlations.push_back(translate_access(kind, addr, data));
		items_sent++;
	endtask

	task automatic send_prg_read();
		logic [15:0] a;
		a = 16'($urandom);
		a[15] = 1'b1;
		send_access(REQ_CPU_RD, a, 8'($urandom_range(0, 255)));
	endtask

	// Five serial writes with random content; now and then a load reset
	// breaks the sequence, and PRG reads are mixed in between.
	task automatic send_serial_load();
		logic [15:0] a;
		logic [7:0]  d;
		int          k;
		for (k = 0; k < 5; k++) begin
			a = 16'($urandom);
			a[15] = 1'b1;
			d = 8'($urandom_range(0, 255));
			d[7] = ($urandom_range(0, 29) == 0);
			if ($urandom_range(0, 3) == 0) send_prg_read();
			send_access(REQ_CPU_WR, a, d);
		end
	endtask

	// Drop valid and wait for every predicted result to come back.
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_xlations.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// APB write: setup cycle, then access cycle until pready.
	task automatic write_config(input logic idx, input logic [4:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {27'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx == REG_PRG_COUNT) prg_count = value;
		else chr_count = value;
	endtask

	task automatic run_random_traffic(input int unsigned n);
		int unsigned first;
		int unsigned sel;
		logic [15:0] a;
		logic [1:0]  kind;
		first = items_sent;
		while (items_sent - first < n) begin
			sel = $urandom_range(0, 99);
			a   = 16'($urandom);
			if (sel < 30) begin
				send_serial_load();
			end else if (sel < 58) begin
				send_prg_read();
			end else if (sel < 78) begin
				// PPU side, mostly inside pattern space
				kind = $urandom_range(0, 1) ? REQ_PPU_WR : REQ_PPU_RD;
				if ($urandom_range(0, 7) != 0) a[15:13] = 3'b000;
				send_access(kind, a, 8'($urandom_range(0, 255)));
			end else if (sel < 88 || written_list.size() == 0) begin
				send_access(REQ_CPU_WR, {3'b011, a[12:0]}, 8'($urandom_range(0, 255)));
			end else if (sel < 96) begin
				// read back only offsets already written
				send_access(REQ_CPU_RD,
					{3'b011, written_list[$urandom_range(0, written_list.size() - 1)]},
					8'($urandom_range(0, 255)));
			end else begin
				// noise: unmapped CPU space or a stray load reset
				kind = $urandom_range(0, 1) ? REQ_CPU_WR : REQ_CPU_RD;
				if ($urandom_range(0, 1))
					send_access(kind, 16'($urandom_range(0, 16'h5FFF)), a[7:0]);
				else send_access(REQ_CPU_WR, {1'b1, a[14:0]}, LOAD_RESET | a[7:0]);
			end
		end
	endtask

	task automatic run_bank_phase(input logic [4:0] prg, input logic [4:0] chr);
		wait_drained();
		write_config(REG_PRG_COUNT, prg);
		write_config(REG_CHR_COUNT, chr);
		run_random_traffic(PHASE_ITEMS);
	endtask

	// Power-on state: window edges on both buses, PRG in 16 KB mode with the
	// last bank fixed high, CHR RAM pass-through.
	task automatic test_bus_windows();
		send_access(REQ_CPU_RD, 16'h0000, 8'h00);
		send_access(REQ_CPU_WR, 16'h5FFF, 8'hFF);
		send_access(REQ_CPU_WR, 16'h6000, 8'hFF);
		send_access(REQ_CPU_WR, 16'h7FFF, 8'h00);
		send_access(REQ_CPU_RD, 16'h6000, 8'h00);
		send_access(REQ_CPU_RD, 16'h7FFF, 8'hFF);
		send_access(REQ_CPU_RD, 16'h8000, 8'h00);
		send_access(REQ_CPU_RD, 16'hBFFF, 8'h00);
		send_access(REQ_CPU_RD, 16'hC000, 8'h00);
		send_access(REQ_CPU_RD, 16'hFFFF, 8'h00);
		send_access(REQ_PPU_RD, 16'h0000, 8'h00);
		send_access(REQ_PPU_WR, 16'h1FFF, 8'hFF);
		send_access(REQ_PPU_RD, 16'h2000, 8'h00);
		send_access(REQ_PPU_WR, 16'hFFFF, 8'hFF);
	endtask

	// Partial load cut by a load reset, then a full load of the control
	// register (vertical mirroring, 32 KB PRG, 8 KB CHR); only bit 0 counts.
	task automatic test_serial_loads();
		send_access(REQ_CPU_WR, 16'h8000, 8'h01);
		send_access(REQ_CPU_WR, 16'h8000, 8'h00);
		send_access(REQ_CPU_WR, 16'hFFFF, LOAD_RESET);
		send_access(REQ_CPU_WR, 16'h9FFF, 8'h7E);
		send_access(REQ_CPU_WR, 16'h9FFF, 8'h7F);
		send_access(REQ_CPU_WR, 16'h9FFF, 8'h7E);
		send_access(REQ_CPU_WR, 16'h9FFF, 8'h40);
		send_access(REQ_CPU_WR, 16'h9FFF, 8'h00);
		send_access(REQ_CPU_RD, 16'hFFFF, 8'h00);
	endtask

	// Bank counts at both ends of range, out of range, and in between.
	task automatic test_bank_count_sweep();
		run_bank_phase(5'd1, 5'd16);
		run_bank_phase(5'd16, 5'd0);
		run_bank_phase(5'd0, 5'd31);
		run_bank_phase(5'd8, 5'd1);
		run_bank_phase(5'($urandom_range(1, 16)), 5'($urandom_range(1, 16)));
	endtask

	// Full-rate stretch: no idling on either side.
	task automatic test_back_to_back();
		idling_on = 1'b0;
		wait_drained();
		while (out_stall) @(posedge clk);
		write_config(REG_PRG_COUNT, 5'($urandom_range(1, 16)));
		write_config(REG_CHR_COUNT, 5'($urandom_range(0, 16)));
		run_random_traffic(FINAL_ITEMS);
	endtask

	// Result channel stall bursts
	initial begin
		forever begin
			@(posedge clk);
			if (idling_on && $urandom_range(0, 9) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 19)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// Every result transfer is checked against the oldest prediction.
	always @(posedge clk) begin : result_check
		xlation_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_xlations.size() == 0) begin
				if (fail_count < 10)
					$display("unexpected result: outcome %0d rom_addr %05h read_data %02h",
						outcome, rom_addr, read_data);
				fail_count++;
			end else begin
				want = expected_xlations.pop_front();
				if (outcome !== want.outcome || rom_addr !== want.rom_addr ||
						read_data !== want.read_data || mirror_mode !== want.mirror) begin
					if (fail_count < 10) begin
						$write("mismatch (exp/got): outcome %0d/%0d rom_addr %05h/%05h ",
							want.outcome, outcome, want.rom_addr, rom_addr);
						$display("read_data %02h/%02h mirror %0d/%0d",
							want.read_data, read_data, want.mirror, mirror_mode);
					end
					fail_count++;
				end
			end
		end
	end

	initial begin
		idling_on = 1'b1;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_bus_windows();
		test_serial_loads();
		test_bank_count_sweep();
		test_back_to_back();
		wait_drained();
		if (fail_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("Some tests failed");
		$finish;
	end

endmodule
